[src/buffer_pool_page_replacer_top_defines.svh]
// assertion macros for the buffer pool page replacer
`ifndef BUFFER_POOL_PAGE_REPLACER_TOP_DEFINES_SVH
`define BUFFER_POOL_PAGE_REPLACER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPR_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define BPR_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define BPR_ASSERT_IMPL(label, clk, rst, prop)
`define BPR_ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/bpr_pkg.sv]
// package for the buffer pool page replacer: types, constants, codes
package bpr_pkg;
  localparam int Frames = 16;
  localparam int FrameBits = 4;
  localparam int PageBits = 16;
  localparam int PinBits = 8;

  localparam logic [2:0] CmdPin = 3'd0;
  localparam logic [2:0] CmdUnpin = 3'd1;
  localparam logic [2:0] CmdDirty = 3'd2;
  localparam logic [2:0] CmdForce = 3'd3;
  localparam logic [2:0] CmdFlush = 3'd4;

  localparam logic RegPolicy = 1'b0;
  localparam logic RegFrames = 1'b1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [PageBits-1:0] page_num;
  } in_item_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame;
    logic hit;
    logic evict_valid;
    logic [PageBits-1:0] evict_page;
    logic write_back;
    logic load_page;
    logic status;
    logic [31:0] read_total;
    logic [31:0] write_total;
    logic last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ACT, ST_FRONT, ST_FLUSH, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic act;
    logic front_step;
    logic flush_step;
  } ctl_t;

  typedef struct packed {
    logic scan_end;
    logic is_flush;
    logic need_front;
    logic front_end;
    logic flush_end;
  } sts_t;
endpackage

[src/bpr_ctrl.sv]
// controller state machine sequencing scan, update, reorder and flush
module bpr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  bpr_pkg::sts_t sts,
  output bpr_pkg::ctl_t ctl
);
  bpr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bpr_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpr_pkg::ST_IDLE: if (start) state_next = bpr_pkg::ST_SCAN;
      bpr_pkg::ST_SCAN: begin
        if (sts.scan_end) state_next = sts.is_flush ? bpr_pkg::ST_FLUSH : bpr_pkg::ST_ACT;
      end
      bpr_pkg::ST_ACT: state_next = sts.need_front ? bpr_pkg::ST_FRONT : bpr_pkg::ST_DONE;
      bpr_pkg::ST_FRONT: if (sts.front_end) state_next = bpr_pkg::ST_DONE;
      bpr_pkg::ST_FLUSH: if (sts.flush_end) state_next = bpr_pkg::ST_DONE;
      bpr_pkg::ST_DONE: state_next = bpr_pkg::ST_IDLE;
      default: state_next = bpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b1;
    unique case (state)
      bpr_pkg::ST_IDLE: begin
        busy = 1'b0;
        ctl.load = start;
      end
      bpr_pkg::ST_SCAN: ctl.scan_step = 1'b1;
      bpr_pkg::ST_ACT: ctl.act = 1'b1;
      bpr_pkg::ST_FRONT: ctl.front_step = 1'b1;
      bpr_pkg::ST_FLUSH: ctl.flush_step = 1'b1;
      bpr_pkg::ST_DONE: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end
endmodule

[src/bpr_datapath.sv]
// frame table datapath: serial scan, update, reorder and flush walk
module bpr_datapath (
  input  logic clk,
  input  logic rst,
  input  bpr_pkg::in_item_t in_item,
  input  logic policy,
  input  logic [4:0] frames_in_use,
  input  bpr_pkg::ctl_t ctl,
  output bpr_pkg::sts_t sts,
  output logic done,
  output bpr_pkg::out_item_t result
);
  localparam int FB = bpr_pkg::FrameBits;
  localparam int PB = bpr_pkg::PageBits;
  localparam int N = bpr_pkg::Frames;

  logic [PB-1:0] frame_page [N];
  logic [N-1:0] frame_valid, dirty_flag;
  logic [bpr_pkg::PinBits-1:0] pin_count [N];
  logic [FB-1:0] order_rank [N];
  logic [FB:0] frames_filled;
  logic [31:0] read_total_reg, write_total_reg;

  logic [2:0] cmd;
  logic [PB-1:0] page;
  logic [FB:0] idx;
  logic found, free_found, vic_found;
  logic [FB-1:0] found_f, free_f, vic_f, tgt, tgt_rank;
  logic [FB:0] limit;
  logic [FB-1:0] cur;

  assign cur = idx[FB-1:0];
  assign limit = (frames_in_use > 5'(N)) ? (FB+1)'(N) : frames_in_use[FB:0];

  assign sts.scan_end = idx[FB];
  assign sts.is_flush = (cmd == bpr_pkg::CmdFlush);
  assign sts.front_end = idx[FB];
  assign sts.flush_end = idx[FB];
  assign sts.need_front = (cmd == bpr_pkg::CmdPin) &&
    (found ? policy : ((free_found && frames_filled < limit) || vic_found));

  // flush walk: rank cur, frame holding it
  logic [FB-1:0] rank_frame;
  always_comb begin
    rank_frame = '0;
    for (int i = 0; i < N; i++)
      if (order_rank[i] == cur) rank_frame = FB'(i);
  end

  logic fl_hit;
  assign fl_hit = frame_valid[rank_frame] && dirty_flag[rank_frame];
  logic [N-1:0] dirty_later;
  always_comb begin
    for (int i = 0; i < N; i++)
      dirty_later[i] = frame_valid[i] && dirty_flag[i] && order_rank[i] > cur;
  end

  logic fl_emit;
  assign fl_emit = ctl.flush_step && !idx[FB] && fl_hit;

  // result of the update cycle
  bpr_pkg::out_item_t act_res;
  always_comb begin
    act_res = '0;
    act_res.last = 1'b1;
    act_res.read_total = read_total_reg;
    act_res.write_total = write_total_reg;
    if (cmd == bpr_pkg::CmdPin) begin
      if (found) begin
        act_res.frame = found_f;
        act_res.hit = 1'b1;
      end else if (free_found && frames_filled < limit) begin
        act_res.frame = free_f;
        act_res.load_page = 1'b1;
        act_res.read_total = read_total_reg + 1'b1;
      end else if (vic_found) begin
        act_res.frame = vic_f;
        act_res.evict_valid = 1'b1;
        act_res.evict_page = frame_page[vic_f];
        act_res.write_back = dirty_flag[vic_f];
        act_res.load_page = 1'b1;
        act_res.read_total = read_total_reg + 1'b1;
        act_res.write_total = write_total_reg + 32'(dirty_flag[vic_f]);
      end else begin
        act_res.status = 1'b1;
      end
    end else if (found && (cmd == bpr_pkg::CmdUnpin || cmd == bpr_pkg::CmdDirty ||
                 cmd == bpr_pkg::CmdForce)) begin
      act_res.frame = found_f;
      act_res.hit = 1'b1;
      if (cmd == bpr_pkg::CmdForce && dirty_flag[found_f]) begin
        act_res.evict_page = page;
        act_res.write_back = 1'b1;
        act_res.write_total = write_total_reg + 1'b1;
      end
    end
  end

  // result of one flush step
  bpr_pkg::out_item_t fl_res;
  always_comb begin
    fl_res = '0;
    fl_res.frame = rank_frame;
    fl_res.hit = 1'b1;
    fl_res.evict_page = frame_page[rank_frame];
    fl_res.write_back = 1'b1;
    fl_res.read_total = read_total_reg;
    fl_res.write_total = write_total_reg + 1'b1;
    fl_res.last = (dirty_later == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      dirty_flag <= '0;
      for (int i = 0; i < N; i++) begin
        pin_count[i] <= '0;
        order_rank[i] <= FB'(i);
      end
      frames_filled <= '0;
      read_total_reg <= '0;
      write_total_reg <= '0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= ctl.act || fl_emit;
      if (ctl.act) result <= act_res;
      else if (fl_emit) result <= fl_res;
      if (ctl.load) begin
        cmd <= in_item.cmd;
        page <= in_item.page_num;
        idx <= '0;
        found <= 1'b0;
        free_found <= 1'b0;
        vic_found <= 1'b0;
      end
      if (ctl.scan_step && !idx[FB]) begin
        if (frame_valid[cur] && frame_page[cur] == page && !found) begin
          found <= 1'b1;
          found_f <= cur;
        end
        if ({1'b0, order_rank[cur]} == frames_filled) begin
          free_found <= 1'b1;
          free_f <= cur;
        end
        if (frame_valid[cur] && pin_count[cur] == '0 &&
            (!vic_found || order_rank[cur] > order_rank[vic_f])) begin
          vic_found <= 1'b1;
          vic_f <= cur;
        end
        idx <= idx + 1'b1;
      end
      if (ctl.scan_step && idx[FB]) idx <= '0;
      if (ctl.act) begin
        if (cmd == bpr_pkg::CmdPin) begin
          if (found) begin
            if (pin_count[found_f] != '1) pin_count[found_f] <= pin_count[found_f] + 1'b1;
            tgt <= found_f;
            tgt_rank <= order_rank[found_f];
          end else if (free_found && frames_filled < limit) begin
            frames_filled <= frames_filled + 1'b1;
            frame_page[free_f] <= page;
            frame_valid[free_f] <= 1'b1;
            dirty_flag[free_f] <= 1'b0;
            pin_count[free_f] <= 8'd1;
            read_total_reg <= read_total_reg + 1'b1;
            tgt <= free_f;
            tgt_rank <= order_rank[free_f];
          end else if (vic_found) begin
            frame_page[vic_f] <= page;
            dirty_flag[vic_f] <= 1'b0;
            pin_count[vic_f] <= 8'd1;
            read_total_reg <= read_total_reg + 1'b1;
            if (dirty_flag[vic_f]) write_total_reg <= write_total_reg + 1'b1;
            tgt <= vic_f;
            tgt_rank <= order_rank[vic_f];
          end
        end else begin
          if (found && (cmd == bpr_pkg::CmdUnpin || cmd == bpr_pkg::CmdDirty ||
              cmd == bpr_pkg::CmdForce)) begin
            if (cmd == bpr_pkg::CmdUnpin && pin_count[found_f] != '0)
              pin_count[found_f] <= pin_count[found_f] - 1'b1;
            if (cmd == bpr_pkg::CmdDirty) dirty_flag[found_f] <= 1'b1;
            if (cmd == bpr_pkg::CmdForce && dirty_flag[found_f]) begin
              dirty_flag[found_f] <= 1'b0;
              write_total_reg <= write_total_reg + 1'b1;
            end
          end
        end
      end
      if (ctl.front_step) begin
        if (!idx[FB]) begin
          if (cur == tgt) order_rank[cur] <= '0;
          else if (order_rank[cur] < tgt_rank) order_rank[cur] <= order_rank[cur] + 1'b1;
          idx <= idx + 1'b1;
        end
      end
      if (ctl.flush_step && !idx[FB]) begin
        idx <= idx + 1'b1;
        if (fl_hit) begin
          dirty_flag[rank_frame] <= 1'b0;
          write_total_reg <= write_total_reg + 1'b1;
        end
      end
    end
  end
endmodule

[src/buffer_pool_page_replacer_top.sv]
// top level of the buffer pool page replacer with apb register port
//  channel | signals                          | direction
//  command | start, busy, cmd_in              | in
//  result  | result_valid, result             | out
//  config  | psel penable pwrite paddr pwdata | in, prdata/pready out
// a pin/unpin/dirty/force item keeps busy high through a serial scan over the
// frame table, an update step, a done state, and for a pin that reorders a
// reorder walk; flush keeps it high through the scan, a walk in rank order
// emitting one item per dirty frame, and a done state.
// rst is synchronous and clears the table, order and totals.
// results appear for one cycle each; the receiver cannot stall them.
`include "buffer_pool_page_replacer_top_defines.svh"
module buffer_pool_page_replacer_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  bpr_pkg::in_item_t cmd_in,
  output logic result_valid,
  output bpr_pkg::out_item_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic policy;
  logic [4:0] frames_in_use;
  bpr_pkg::ctl_t ctl;
  bpr_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
      frames_in_use <= 5'd16;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == bpr_pkg::RegPolicy) policy <= pwdata[0];
      else frames_in_use <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == bpr_pkg::RegPolicy) prdata = {31'd0, policy};
      else prdata = {27'd0, frames_in_use};
    end
  end

  bpr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  bpr_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(cmd_in), .policy(policy),
    .frames_in_use(frames_in_use), .ctl(ctl), .sts(sts),
    .done(result_valid), .result(result)
  );

  `BPR_ASSERT_IMPL(a_no_start_accept_busy, clk, rst, (result_valid && result.last) |=> !result_valid)
  `BPR_ASSERT_IMPL(a_one_hot_act, clk, rst, $onehot0({ctl.scan_step, ctl.act, ctl.front_step, ctl.flush_step}))
  `BPR_ASSERT_IMPL(a_load_idle, clk, rst, ctl.load |=> busy)
endmodule

[verif/tb.sv]
// testbench for the buffer pool page replacer checked against a predictor
module tb;
  localparam int WatchLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bpr_pkg::in_item_t cmd_in = '0;
  logic result_valid;
  bpr_pkg::out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  buffer_pool_page_replacer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [bpr_pkg::PageBits-1:0] pg_of[bpr_pkg::Frames];
  logic resident[bpr_pkg::Frames];
  logic dirty[bpr_pkg::Frames];
  logic [bpr_pkg::PinBits-1:0] pins[bpr_pkg::Frames];
  logic [bpr_pkg::FrameBits-1:0] rank[bpr_pkg::Frames];
  int unsigned filled;
  logic [31:0] reads, writes;
  logic lru_mode;
  logic [4:0] fill_limit;

  bpr_pkg::in_item_t pending_cmds[$];
  bpr_pkg::out_item_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int accepted_cmds = 0;
  logic failed = 1'b0;

  function automatic bpr_pkg::out_item_t make_res(int fr, logic h, logic ev,
                                                  logic [bpr_pkg::PageBits-1:0] evp,
                                                  logic wb, logic ld, logic st, logic lst);
    bpr_pkg::out_item_t r;
    r.frame = fr[bpr_pkg::FrameBits-1:0];
    r.hit = h;
    r.evict_valid = ev;
    r.evict_page = evp;
    r.write_back = wb;
    r.load_page = ld;
    r.status = st;
    r.read_total = reads;
    r.write_total = writes;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup(logic [bpr_pkg::PageBits-1:0] p);
    for (int i = 0; i < bpr_pkg::Frames; i++)
      if (resident[i] && pg_of[i] == p) return i;
    return -1;
  endfunction

  function automatic void move_front(int f);
    logic [bpr_pkg::FrameBits-1:0] r;
    r = rank[f];
    for (int i = 0; i < bpr_pkg::Frames; i++)
      if (rank[i] < r) rank[i] = rank[i] + 1'b1;
    rank[f] = '0;
  endfunction

  function automatic void predict_pin(logic [bpr_pkg::PageBits-1:0] p);
    int f, victim;
    int unsigned lim;
    logic [bpr_pkg::PageBits-1:0] old;
    logic wb;
    f = lookup(p);
    victim = -1;
    if (f >= 0) begin
      if (pins[f] != 8'hff) pins[f] = pins[f] + 1'b1;
      if (lru_mode) move_front(f);
      expected_results.push_back(make_res(f, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
      return;
    end
    lim = (fill_limit < bpr_pkg::Frames) ? fill_limit : bpr_pkg::Frames;
    if (filled < lim) begin
      for (int i = 0; i < bpr_pkg::Frames; i++)
        if (rank[i] == filled) f = i;
      if (f >= 0) begin
        filled++;
        pg_of[f] = p;
        resident[f] = 1'b1;
        dirty[f] = 1'b0;
        pins[f] = 8'd1;
        reads++;
        move_front(f);
        expected_results.push_back(make_res(f, 1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
        return;
      end
    end
    for (int i = 0; i < bpr_pkg::Frames; i++)
      if (resident[i] && pins[i] == 0 && (victim < 0 || rank[i] > rank[victim])) victim = i;
    if (victim < 0) begin
      expected_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
      return;
    end
    old = pg_of[victim];
    wb = dirty[victim];
    if (wb) writes++;
    pg_of[victim] = p;
    dirty[victim] = 1'b0;
    pins[victim] = 8'd1;
    reads++;
    move_front(victim);
    expected_results.push_back(make_res(victim, 1'b0, 1'b1, old, wb, 1'b1, 1'b0, 1'b1));
  endfunction

  function automatic void predict_cmd(bpr_pkg::in_item_t it);
    int f, n;
    logic wb;
    case (it.cmd)
      bpr_pkg::CmdPin: predict_pin(it.page_num);
      bpr_pkg::CmdUnpin, bpr_pkg::CmdDirty, bpr_pkg::CmdForce: begin
        f = lookup(it.page_num);
        if (f < 0) begin
          expected_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else if (it.cmd == bpr_pkg::CmdUnpin) begin
          if (pins[f] != 0) pins[f] = pins[f] - 1'b1;
          expected_results.push_back(make_res(f, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else if (it.cmd == bpr_pkg::CmdDirty) begin
          dirty[f] = 1'b1;
          expected_results.push_back(make_res(f, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          wb = dirty[f];
          if (wb) begin
            dirty[f] = 1'b0;
            writes++;
          end
          expected_results.push_back(make_res(f, 1'b1, 1'b0, wb ? it.page_num : '0, wb,
                                              1'b0, 1'b0, 1'b1));
        end
      end
      bpr_pkg::CmdFlush: begin
        n = 0;
        for (int r = 0; r < bpr_pkg::Frames; r++)
          for (int i = 0; i < bpr_pkg::Frames; i++)
            if (rank[i] == r && resident[i] && dirty[i]) begin
              dirty[i] = 1'b0;
              writes++;
              expected_results.push_back(make_res(i, 1'b1, 1'b0, pg_of[i], 1'b1, 1'b0, 1'b0,
                                                  1'b0));
              n++;
            end
        if (n > 0) expected_results[$].last = 1'b1;
      end
      default: expected_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
    endcase
  endfunction

  // acceptance, prediction and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid || (start && !busy) || (psel && penable && pwrite && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          if (result !== expected_results[0]) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_results[0], result);
          end
          void'(expected_results.pop_front());
        end
      end
      if (start && !busy) begin
        predict_cmd(cmd_in);
        void'(pending_cmds.pop_front());
        accepted_cmds++;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // driver
  logic sent = 1'b0;
  always @(posedge clk) sent <= start && !busy;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !sent) begin
      start <= 1'b1;
    end else if (pending_cmds.size() != 0 &&
                 ((accepted_cmds > 120 && accepted_cmds < 200) || $urandom_range(99) >= 24)) begin
      start <= 1'b1;
      cmd_in <= pending_cmds[0];
    end else begin
      start <= 1'b0;
      cmd_in <= bpr_pkg::in_item_t'(19'($urandom));
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == 3'd4 * bpr_pkg::RegPolicy) lru_mode = val[0];
    else fill_limit = val[4:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    wait (!busy && pending_cmds.size() == 0);
  endtask

  task automatic push_cmd(logic [2:0] c, logic [bpr_pkg::PageBits-1:0] p);
    bpr_pkg::in_item_t it;
    it.cmd = c;
    it.page_num = p;
    pending_cmds.push_back(it);
  endtask

  task automatic random_phase(int count, int pool);
    int u;
    logic [2:0] c;
    logic [bpr_pkg::PageBits-1:0] p;
    for (int k = 0; k < count; k++) begin
      u = $urandom_range(99);
      if (u < 40) c = bpr_pkg::CmdPin;
      else if (u < 65) c = bpr_pkg::CmdUnpin;
      else if (u < 80) c = bpr_pkg::CmdDirty;
      else if (u < 88) c = bpr_pkg::CmdForce;
      else if (u < 95) c = bpr_pkg::CmdFlush;
      else c = 3'($urandom_range(7, 5));
      if ($urandom_range(9) == 0) p = 16'($urandom);
      else p = 16'($urandom_range(pool - 1)) ^ 16'ha5c3;
      push_cmd(c, p);
    end
  endtask

  initial begin
    for (int i = 0; i < bpr_pkg::Frames; i++) begin
      pg_of[i] = '0;
      resident[i] = 1'b0;
      dirty[i] = 1'b0;
      pins[i] = '0;
      rank[i] = bpr_pkg::FrameBits'(i);
    end
    filled = 0;
    reads = '0;
    writes = '0;
    lru_mode = 1'b0;
    fill_limit = 5'd16;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    reg_write(3'd4 * bpr_pkg::RegFrames, 32'd2);
    reg_write(3'd4 * bpr_pkg::RegPolicy, 32'd0);
    // small pool: fill, pinned-out miss, eviction, dirty paths, odd codes
    push_cmd(bpr_pkg::CmdUnpin, 16'h0000);
    push_cmd(bpr_pkg::CmdFlush, 16'h0000);
    push_cmd(bpr_pkg::CmdPin, 16'h0000);
    push_cmd(bpr_pkg::CmdPin, 16'hffff);
    push_cmd(bpr_pkg::CmdPin, 16'h1234);
    push_cmd(bpr_pkg::CmdUnpin, 16'h0000);
    push_cmd(bpr_pkg::CmdUnpin, 16'h0000);
    push_cmd(bpr_pkg::CmdDirty, 16'h0000);
    push_cmd(bpr_pkg::CmdPin, 16'hffff);
    push_cmd(bpr_pkg::CmdPin, 16'h5555);
    push_cmd(bpr_pkg::CmdDirty, 16'h5555);
    push_cmd(bpr_pkg::CmdDirty, 16'hffff);
    push_cmd(bpr_pkg::CmdForce, 16'h5555);
    push_cmd(bpr_pkg::CmdForce, 16'h5555);
    push_cmd(bpr_pkg::CmdForce, 16'haaaa);
    push_cmd(bpr_pkg::CmdDirty, 16'haaaa);
    push_cmd(bpr_pkg::CmdFlush, 16'h0000);
    push_cmd(bpr_pkg::CmdFlush, 16'h0000);
    push_cmd(3'd5, 16'hffff);
    push_cmd(3'd6, 16'h0001);
    push_cmd(3'd7, 16'h8000);
    drain();

    reg_write(3'd4 * bpr_pkg::RegPolicy, 32'd1);
    reg_write(3'd4 * bpr_pkg::RegFrames, 32'd16);
    random_phase(120, 24);
    drain();

    reg_write(3'd4 * bpr_pkg::RegPolicy, 32'd0);
    reg_write(3'd4 * bpr_pkg::RegFrames, 32'd1);
    random_phase(60, 6);
    drain();

    reg_write(3'd4 * bpr_pkg::RegFrames, 32'd9);
    random_phase(100, 32);
    drain();

    if (!failed && mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
